FILE: rtl/stramp_pkg.sv
// stramp_pkg: shared constants for the trapezoidal stepper ramp
// register indexes, operation codes, reset values and divider sizes
// no dependencies
`timescale 1ns / 1ps

package stramp_pkg;

    localparam int POS_BITS_DEF = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int DIV_BITS = 64;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SPEED  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_SPEED  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACCEL      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_CLOCK = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POLARITY   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DISABLE    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SWAP       = 3'd6;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_ABORT  = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    localparam logic [31:0] RST_MIN_SPEED  = 32'd100;
    localparam logic [31:0] RST_MAX_SPEED  = 32'd1000;
    localparam logic [31:0] RST_ACCEL      = 32'd1000;
    localparam logic [31:0] RST_BASE_CLOCK = 32'd1000000;

    localparam logic [32:0] SAT_LIMIT = 33'h1_0000_0000;

endpackage

FILE: rtl/stepper_trapezoid_ramp_top.sv
// stepper_trapezoid_ramp_top: trapezoidal stepper speed ramp and pulse timer values
// depends on stramp_pkg and stramp_div
//
// Requests enter on the in channel (valid/ready) with op, target, steps_done
// and switch_levels; one result leaves on the out channel (valid/ready) for
// every request. Registers are written through a plain write port (enable, index,
// data); the user must write them only while idle; the block does not check it.
// One request is worked at a time: in ready is low from acceptance until its
// result is taken. All divisions share the one 64-bit divider and products
// come from the single 32x32 multiplier; the work per request is:
//   abort, finish or any request while idle: no division (speed is 0)
//   start that finds the motor at the target: no division (speed is 0)
//   blocked update: the timer division only
//   update: the timer division, plus a product and one ramp division inside a ramp
//   start: two ramp divisions and the timer division
// Timer reload and compare come from base_clock / speed on the same divider.
// A result is held on the out ports until the receiver takes it; a stalled
// receiver stalls the block. Synchronous reset clears position, speed, the
// move state and loads the register defaults; the block is ready at once.
`timescale 1ns / 1ps

module stepper_trapezoid_ramp_top #(
    parameter int POS_BITS = stramp_pkg::POS_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [stramp_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [stramp_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [1:0]                             i_op,
    input  logic signed [31:0]                     i_target,
    input  logic [31:0]                            i_steps_done,
    input  logic [1:0]                             i_switch_levels,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [31:0]                     o_position,
    output logic [31:0]                            o_speed,
    output logic [31:0]                            o_timer_reload,
    output logic [31:0]                            o_timer_compare,
    output logic [31:0]                            o_ramp_len,
    output logic                                   o_moving,
    output logic                                   o_halted,
    output logic                                   o_dir_fwd
);

    typedef enum logic [2:0] {
        S_IDLE, S_CHK, S_MUL, S_DGO, S_DWAIT, S_TIMER, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_A, PH_B, PH_UP_DEC, PH_UP_ACC, PH_TIMER
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    logic [31:0] r_min, r_max, r_acc, r_base;
    logic [1:0]  r_pol, r_dis;
    logic        r_swap;

    logic [POS_BITS-1:0] r_start_pos, r_cur_pos, r_tgt;
    logic                r_dir, r_busy, r_halted;
    logic [31:0]         r_len, r_ramp, r_speed, r_reload, r_cmp;

    logic [31:0] r_ma, r_mb, r_dvs;
    logic [63:0] r_prod;
    logic [32:0] r_sat_a;
    logic        div_start, div_done;
    logic [63:0] div_q;

    logic [31:0]           top, dv, decel_at, k;
    logic [POS_BITS-1:0]   steps_p, along, len_p;
    logic [1:0]            sw;
    logic                  blocked;
    logic signed [POS_BITS:0] diff;
    logic [POS_BITS:0]     mag;
    logic [63:0]           q_half;
    logic [32:0]           sat_a_n, sat_b;
    logic [33:0]           ramp_sum;
    logic [31:0]           period;

    assign top      = (r_max < r_min) ? r_min : r_max;
    assign dv       = top - r_min;
    assign decel_at = r_len - r_ramp;
    assign k        = i_steps_done - decel_at;
    assign steps_p  = i_steps_done[POS_BITS-1:0];
    assign len_p    = r_len[POS_BITS-1:0];
    assign along    = r_dir ? r_start_pos + steps_p : r_start_pos - steps_p;

    always_comb begin
        if (r_dir) begin
            sw = r_swap ? 2'b01 : 2'b10;
        end else begin
            sw = r_swap ? 2'b10 : 2'b01;
        end
        blocked = ((r_dis & sw) == 2'b00) && (((r_pol ^ i_switch_levels) & sw) != 2'b00);
    end

    assign diff = $signed({r_tgt[POS_BITS-1], r_tgt})
                - $signed({r_cur_pos[POS_BITS-1], r_cur_pos});
    assign mag  = diff[POS_BITS] ? (POS_BITS+1)'(-diff) : diff;

    assign q_half   = div_q >> 1;
    assign sat_a_n  = (q_half > 64'(stramp_pkg::SAT_LIMIT)) ? stramp_pkg::SAT_LIMIT
                                                            : q_half[32:0];
    assign sat_b    = (div_q > 64'(stramp_pkg::SAT_LIMIT)) ? stramp_pkg::SAT_LIMIT
                                                           : div_q[32:0];
    assign ramp_sum = {1'b0, r_sat_a} + {1'b0, sat_b};
    assign period   = div_q[31:0];

    assign div_start = (r_state == S_DGO);

    stramp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= stramp_pkg::RST_MIN_SPEED;
            r_max       <= stramp_pkg::RST_MAX_SPEED;
            r_acc       <= stramp_pkg::RST_ACCEL;
            r_base      <= stramp_pkg::RST_BASE_CLOCK;
            r_pol       <= 2'b00;
            r_dis       <= 2'b00;
            r_swap      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                stramp_pkg::CFG_MIN_SPEED:  r_min  <= i_cfg_data;
                stramp_pkg::CFG_MAX_SPEED:  r_max  <= i_cfg_data;
                stramp_pkg::CFG_ACCEL:      r_acc  <= i_cfg_data;
                stramp_pkg::CFG_BASE_CLOCK: r_base <= i_cfg_data;
                stramp_pkg::CFG_POLARITY:   r_pol  <= i_cfg_data[1:0];
                stramp_pkg::CFG_DISABLE:    r_dis  <= i_cfg_data[1:0];
                stramp_pkg::CFG_SWAP:       r_swap <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_A;
            r_start_pos <= '0;
            r_cur_pos   <= '0;
            r_dir       <= 1'b0;
            r_len       <= '0;
            r_ramp      <= '0;
            r_speed     <= '0;
            r_busy      <= 1'b0;
            r_halted    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_halted <= r_busy && (i_op == stramp_pkg::OP_UPDATE) && blocked;
                        if (i_op == stramp_pkg::OP_START) begin
                            r_tgt   <= i_target[POS_BITS-1:0];
                            r_state <= S_CHK;
                            if (r_busy) begin
                                r_cur_pos <= along;
                                r_speed   <= '0;
                                r_busy    <= 1'b0;
                            end
                        end else if (r_busy) begin
                            case (i_op)
                                stramp_pkg::OP_UPDATE: begin
                                    if (blocked) begin
                                        r_state <= S_TIMER;
                                    end else begin
                                        r_cur_pos <= along;
                                        r_mb      <= dv;
                                        r_dvs     <= r_ramp;
                                        if (i_steps_done >= decel_at) begin
                                            if (k >= r_ramp) begin
                                                r_speed <= r_min;
                                                r_state <= S_TIMER;
                                            end else begin
                                                r_ma    <= k;
                                                r_phase <= PH_UP_DEC;
                                                r_state <= S_MUL;
                                            end
                                        end else if (i_steps_done < r_ramp) begin
                                            r_ma    <= i_steps_done;
                                            r_phase <= PH_UP_ACC;
                                            r_state <= S_MUL;
                                        end else begin
                                            r_speed <= top;
                                            r_state <= S_TIMER;
                                        end
                                    end
                                end
                                stramp_pkg::OP_ABORT: begin
                                    r_cur_pos <= along;
                                    r_speed   <= '0;
                                    r_busy    <= 1'b0;
                                    r_state   <= S_TIMER;
                                end
                                default: begin
                                    r_cur_pos <= r_dir ? r_start_pos + len_p
                                                       : r_start_pos - len_p;
                                    r_speed   <= '0;
                                    r_busy    <= 1'b0;
                                    r_state   <= S_TIMER;
                                end
                            endcase
                        end else begin
                            r_state <= S_TIMER;
                        end
                    end
                end
                S_CHK: begin
                    if (diff == '0) begin
                        r_state <= S_TIMER;
                    end else begin
                        r_start_pos <= r_cur_pos;
                        r_dir       <= !diff[POS_BITS];
                        r_len       <= 32'(mag);
                        r_ma        <= dv;
                        r_mb        <= dv;
                        r_dvs       <= (r_acc == '0) ? 32'd1 : r_acc;
                        r_phase     <= PH_A;
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_ma * r_mb;
                    r_state <= S_DGO;
                end
                S_DGO: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_done) begin
                        unique case (r_phase)
                            PH_A: begin
                                r_sat_a <= sat_a_n;
                                r_ma    <= r_min;
                                r_mb    <= dv;
                                r_phase <= PH_B;
                                r_state <= S_MUL;
                            end
                            PH_B: begin
                                r_ramp  <= ({ramp_sum, 1'b0} > {3'b000, r_len})
                                           ? (r_len >> 1) : ramp_sum[31:0];
                                r_speed <= r_min;
                                r_busy  <= 1'b1;
                                r_state <= S_TIMER;
                            end
                            PH_UP_DEC: begin
                                r_speed <= top - div_q[31:0];
                                r_state <= S_TIMER;
                            end
                            PH_UP_ACC: begin
                                r_speed <= r_min + div_q[31:0];
                                r_state <= S_TIMER;
                            end
                            default: begin
                                r_reload <= (period == '0) ? '0 : period - 32'd1;
                                r_cmp    <= period >> 1;
                                r_state  <= S_OUT;
                            end
                        endcase
                    end
                end
                S_TIMER: begin
                    if (r_speed == '0) begin
                        r_reload <= '0;
                        r_cmp    <= '0;
                        r_state  <= S_OUT;
                    end else begin
                        r_prod  <= {32'd0, r_base};
                        r_dvs   <= r_speed;
                        r_phase <= PH_TIMER;
                        r_state <= S_DGO;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = (r_state == S_OUT);
    assign o_position      = 32'(signed'(r_cur_pos));
    assign o_speed         = r_speed;
    assign o_timer_reload  = r_reload;
    assign o_timer_compare = r_cmp;
    assign o_ramp_len      = r_ramp;
    assign o_moving        = r_busy;
    assign o_halted        = r_halted;
    assign o_dir_fwd       = r_dir;

endmodule

FILE: rtl/stramp_div.sv
// stramp_div: 64 by 32 bit restoring divider, one quotient bit per cycle
// uses stramp_pkg for sizes
`timescale 1ns / 1ps

module stramp_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [stramp_pkg::DIV_BITS-1:0]  i_dividend,
    input  logic [31:0]                      i_divisor,
    output logic                             o_done,
    output logic [stramp_pkg::DIV_BITS-1:0]  o_quotient
);

    logic                                 r_run, n_run;
    logic                                 r_done, n_done;
    logic [stramp_pkg::DIV_CNT_BITS-1:0]  r_cnt, n_cnt;
    logic [31:0]                          r_rem, n_rem;
    logic [31:0]                          r_dvs, n_dvs;
    logic [stramp_pkg::DIV_BITS-1:0]      r_q, n_q;
    logic [32:0]                          sh;
    logic                                 ge;

    assign sh = {r_rem, r_q[stramp_pkg::DIV_BITS-1]};
    assign ge = sh >= {1'b0, r_dvs};

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_q    = r_q;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = '0;
            n_rem = '0;
            n_dvs = i_divisor;
            n_q   = i_dividend;
        end else if (r_run) begin
            n_rem = ge ? 32'(sh - {1'b0, r_dvs}) : sh[31:0];
            n_q   = {r_q[stramp_pkg::DIV_BITS-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == stramp_pkg::DIV_CNT_BITS'(stramp_pkg::DIV_BITS - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_q   <= n_q;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
